### design/bta_pkg.sv
// shared types and codes for the bakery ticket arbiter
package bta_pkg;

  typedef enum logic [0:0] {
    FUNC_REQUEST = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  localparam int unsigned ActiveBits  = 4;
  localparam int unsigned IdBits      = 3;
  localparam int unsigned OutTktBits  = 16;
  localparam logic [ActiveBits-1:0] ActiveReset = 4'd8;

endpackage

### design/bta_cell.sv
// one ticket cell: holds a requester's ticket and forwards the running max and min pair
module bta_cell
  import bta_pkg::*;
#(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned TICKET_BITS = 16,
  parameter int unsigned ID_BITS     = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   op_en_i,
  input  logic [IdBits-1:0]      op_id_i,
  input  logic                   wr_en_i,
  input  logic [TICKET_BITS-1:0] wr_val_i,
  input  logic                   sw_vld_i,
  input  logic [TICKET_BITS-1:0] sw_max_i,
  input  logic                   sw_bv_i,
  input  logic [TICKET_BITS-1:0] sw_bt_i,
  input  logic [ID_BITS-1:0]     sw_bid_i,
  output logic                   sw_vld_o,
  output logic [TICKET_BITS-1:0] sw_max_o,
  output logic                   sw_bv_o,
  output logic [TICKET_BITS-1:0] sw_bt_o,
  output logic [ID_BITS-1:0]     sw_bid_o
);

  logic [TICKET_BITS-1:0] ticket_q;
  logic                   hit;
  logic                   take;
  logic                   vld_q;
  logic [TICKET_BITS-1:0] max_q, max_d;
  logic                   bv_q, bv_d;
  logic [TICKET_BITS-1:0] bt_q, bt_d;
  logic [ID_BITS-1:0]     bid_q, bid_d;

  // the target cell stays out of the min search, its new value is merged at the end
  assign hit  = op_en_i && (32'(op_id_i) == 32'(INDEX));
  assign take = !hit && (ticket_q != '0) && (!sw_bv_i || ticket_q < sw_bt_i);

  always_comb begin
    max_d = (ticket_q > sw_max_i) ? ticket_q : sw_max_i;
    bv_d  = sw_bv_i;
    bt_d  = sw_bt_i;
    bid_d = sw_bid_i;
    if (take) begin
      bv_d  = 1'b1;
      bt_d  = ticket_q;
      bid_d = ID_BITS'(INDEX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticket_q <= '0;
      vld_q    <= 1'b0;
    end else begin
      vld_q <= sw_vld_i;
      if (wr_en_i && hit) begin
        ticket_q <= wr_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_vld_i) begin
      max_q <= max_d;
      bv_q  <= bv_d;
      bt_q  <= bt_d;
      bid_q <= bid_d;
    end
  end

  assign sw_vld_o = vld_q;
  assign sw_max_o = max_q;
  assign sw_bv_o  = bv_q;
  assign sw_bt_o  = bt_q;
  assign sw_bid_o = bid_q;

endmodule

### design/bakery_ticket_arbiter.sv
// top level of the bakery ticket arbiter: op control, cell chain and result register
//
// channel   | ports                                              | transfer
// ----------+----------------------------------------------------+----------------------
// command   | start_i, func_i, requester_id_i, busy_o            | start_i && !busy_o
// result    | done_o, ticket_o, grant_valid_o, grant_id_o,       | done_o, one cycle
//           | status_o                                           |
// config    | cfg_we_i, cfg_wdata_i                              | cfg_we_i
//
// from transfer to result strobe an item passes the launch register, then a register in
// each cell as the sweep walks the chain, then the result register, loaded with the write-back
// busy_o is low in the cycle the result strobe is high, so the next command can follow
// reset clears every ticket and sets the active count to 8
// the receiver cannot stall; results are presented once
module bakery_ticket_arbiter
  import bta_pkg::*;
#(
  parameter int unsigned MAX_REQUESTERS = 8,
  parameter int unsigned TICKET_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  func_i,
  input  logic [IdBits-1:0]     requester_id_i,
  output logic                  busy_o,
  input  logic                  cfg_we_i,
  input  logic [ActiveBits-1:0] cfg_wdata_i,
  output logic                  done_o,
  output logic [OutTktBits-1:0] ticket_o,
  output logic                  grant_valid_o,
  output logic [IdBits-1:0]     grant_id_o,
  output logic [1:0]            status_o
);

  localparam int unsigned IdW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int unsigned CmpW = (IdW > IdBits) ? IdW : IdBits;
  localparam logic [TICKET_BITS-1:0] TicketMax = '1;

  logic [ActiveBits-1:0] active_q;
  logic                  busy_q;
  logic                  launch_q;
  func_e                 op_func_q;
  logic [IdBits-1:0]     op_id_q;
  logic                  op_inr_q;
  logic                  accept;
  logic                  inr;

  logic                   sw_vld [MAX_REQUESTERS+1];
  logic [TICKET_BITS-1:0] sw_max [MAX_REQUESTERS+1];
  logic                   sw_bv  [MAX_REQUESTERS+1];
  logic [TICKET_BITS-1:0] sw_bt  [MAX_REQUESTERS+1];
  logic [IdW-1:0]         sw_bid [MAX_REQUESTERS+1];

  logic                   last_vld;
  logic                   wr_en;
  logic [TICKET_BITS-1:0] wr_val;
  logic                   sat;
  logic [TICKET_BITS-1:0] new_tkt;
  logic [TICKET_BITS-1:0] res_tkt;
  logic                   res_gv;
  logic [CmpW-1:0]        res_gid;
  status_e                res_st;

  logic                  done_q;
  logic [OutTktBits-1:0] ticket_q;
  logic                  gv_q;
  logic [IdBits-1:0]     gid_q;
  status_e               st_q;

  assign accept = start_i && !busy_q;
  assign inr    = ({1'b0, requester_id_i} < active_q) &&
                  (32'(requester_id_i) < 32'(MAX_REQUESTERS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      launch_q <= accept;
      done_q   <= last_vld;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last_vld) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_func_q <= func_e'(func_i);
      op_id_q   <= requester_id_i;
      op_inr_q  <= inr;
    end
  end

  // sweep seed
  assign sw_vld[0] = launch_q;
  assign sw_max[0] = '0;
  assign sw_bv[0]  = 1'b0;
  assign sw_bt[0]  = '0;
  assign sw_bid[0] = '0;

  for (genvar g = 0; g < MAX_REQUESTERS; g++) begin : g_cell
    bta_cell #(
      .INDEX      (g),
      .TICKET_BITS(TICKET_BITS),
      .ID_BITS    (IdW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_en_i (op_inr_q),
      .op_id_i (op_id_q),
      .wr_en_i (wr_en),
      .wr_val_i(wr_val),
      .sw_vld_i(sw_vld[g]),
      .sw_max_i(sw_max[g]),
      .sw_bv_i (sw_bv[g]),
      .sw_bt_i (sw_bt[g]),
      .sw_bid_i(sw_bid[g]),
      .sw_vld_o(sw_vld[g+1]),
      .sw_max_o(sw_max[g+1]),
      .sw_bv_o (sw_bv[g+1]),
      .sw_bt_o (sw_bt[g+1]),
      .sw_bid_o(sw_bid[g+1])
    );
  end

  assign last_vld = sw_vld[MAX_REQUESTERS];
  assign sat      = (sw_max[MAX_REQUESTERS] == TicketMax);
  assign new_tkt  = sat ? TicketMax : sw_max[MAX_REQUESTERS] + 1'b1;
  assign wr_en    = last_vld && op_inr_q;

  // merge the target's new ticket with the min pair of the other cells
  always_comb begin
    wr_val  = '0;
    res_tkt = '0;
    res_st  = ST_OK;
    res_gv  = sw_bv[MAX_REQUESTERS];
    res_gid = CmpW'(sw_bid[MAX_REQUESTERS]);
    if (!op_inr_q) begin
      res_st = ST_RANGE;
    end else if (op_func_q == FUNC_REQUEST) begin
      wr_val  = new_tkt;
      res_tkt = new_tkt;
      if (sat) begin
        res_st = ST_SAT;
      end
      if (!sw_bv[MAX_REQUESTERS] || new_tkt < sw_bt[MAX_REQUESTERS] ||
          (new_tkt == sw_bt[MAX_REQUESTERS] &&
           CmpW'(op_id_q) < CmpW'(sw_bid[MAX_REQUESTERS]))) begin
        res_gv  = 1'b1;
        res_gid = CmpW'(op_id_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_vld) begin
      ticket_q <= OutTktBits'(res_tkt);
      gv_q     <= res_gv;
      gid_q    <= IdBits'(res_gid);
      st_q     <= res_st;
    end
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign ticket_o      = ticket_q;
  assign grant_valid_o = gv_q;
  assign grant_id_o    = gid_q;
  assign status_o      = st_q;

endmodule

### test/bakery_ticket_arbiter_checker.sv
// checker for the bakery ticket arbiter: predicts each result and compares it with the block
module bakery_ticket_arbiter_checker
  import bta_pkg::*;
#(
  parameter int unsigned MAX_REQUESTERS = 8,
  parameter int unsigned TICKET_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  func_i,
  input  logic [IdBits-1:0]     requester_id_i,
  input  logic                  busy_i,
  input  logic                  cfg_we_i,
  input  logic [ActiveBits-1:0] cfg_wdata_i,
  input  logic                  done_i,
  input  logic [OutTktBits-1:0] ticket_i,
  input  logic                  grant_valid_i,
  input  logic [IdBits-1:0]     grant_id_i,
  input  logic [1:0]            status_i,
  output int                    mismatch_count_o,
  output int                    awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TICKET_BITS-1:0] TicketTop = '1;
  localparam int AwaitDepth = 4;

  typedef struct packed {
    logic [OutTktBits-1:0] ticket;
    logic                  grant_valid;
    logic [IdBits-1:0]     grant_id;
    status_e               status;
  } grant_report_t;

  logic [TICKET_BITS-1:0] held_tickets [MAX_REQUESTERS];
  logic [ActiveBits-1:0]  active_count;
  grant_report_t          awaited_reports [AwaitDepth];
  int                     await_head = 0;
  int                     await_tail = 0;
  int                     await_count = 0;
  int                     mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  task automatic arbitrate_item(input func_e func, input logic [IdBits-1:0] id,
                                output grant_report_t rep);
    logic [TICKET_BITS-1:0] top;
    logic [TICKET_BITS-1:0] best;
    rep  = '0;
    top  = '0;
    best = '0;
    if (id >= active_count || id >= MAX_REQUESTERS) begin
      rep.status = ST_RANGE;
    end else if (func == FUNC_REQUEST) begin
      for (int i = 0; i < MAX_REQUESTERS; i++)
        if (held_tickets[i] > top) top = held_tickets[i];
      if (top == TicketTop) begin
        held_tickets[id] = TicketTop;
        rep.status = ST_SAT;
      end else begin
        held_tickets[id] = top + 1'b1;
        rep.status = ST_OK;
      end
      rep.ticket = OutTktBits'(held_tickets[id]);
    end else begin
      held_tickets[id] = '0;
      rep.status = ST_OK;
    end
    for (int i = 0; i < MAX_REQUESTERS; i++)
      if (held_tickets[i] != '0 && (!rep.grant_valid || held_tickets[i] < best)) begin
        best = held_tickets[i];
        rep.grant_id = IdBits'(i);
        rep.grant_valid = 1'b1;
      end
  endtask

  task automatic log_mismatch(input string what, input grant_report_t want,
                              input grant_report_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%0t %s: expected ticket %0d grant %0b/%0d status %0d, ",
             $time, what, want.ticket, want.grant_valid, want.grant_id, want.status);
      $display("got ticket %0d grant %0b/%0d status %0d",
               got.ticket, got.grant_valid, got.grant_id, got.status);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_report_t want;
    grant_report_t got;
    if (!rst_ni) begin
      foreach (held_tickets[i]) held_tickets[i] = '0;
      active_count = ActiveReset;
      await_head   = 0;
      await_tail   = 0;
      await_count  = 0;
      awaiting_o <= 0;
    end else begin
      if (done_i) begin
        got.ticket      = ticket_i;
        got.grant_valid = grant_valid_i;
        got.grant_id    = grant_id_i;
        got.status      = status_e'(status_i);
        if (await_count == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_reports[await_head];
          await_head = (await_head + 1) % AwaitDepth;
          await_count--;
          if (got !== want) log_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_we_i) active_count = cfg_wdata_i;
      if (start_i && !busy_i) begin
        arbitrate_item(func_e'(func_i), requester_id_i, want);
        awaited_reports[await_tail] = want;
        await_tail = (await_tail + 1) % AwaitDepth;
        await_count++;
      end
      awaiting_o <= await_count;
    end
  end

endmodule

### test/bakery_ticket_arbiter_test.sv
// top of the bakery ticket arbiter testbench: clock, reset, stimulus and verdict
module bakery_ticket_arbiter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start_i        = 1'b0;
  logic                  func_i         = 1'b0;
  logic [IdBits-1:0]     requester_id_i = '0;
  logic                  cfg_we_i       = 1'b0;
  logic [ActiveBits-1:0] cfg_wdata_i    = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [OutTktBits-1:0] ticket_o;
  logic                  grant_valid_o;
  logic [IdBits-1:0]     grant_id_o;
  logic [1:0]            status_o;
  int                    mismatch_count;
  int                    awaiting;
  int                    idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  bakery_ticket_arbiter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .func_i         (func_i),
    .requester_id_i (requester_id_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .ticket_o       (ticket_o),
    .grant_valid_o  (grant_valid_o),
    .grant_id_o     (grant_id_o),
    .status_o       (status_o)
  );

  bakery_ticket_arbiter_checker ticket_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .func_i           (func_i),
    .requester_id_i   (requester_id_i),
    .busy_i           (busy_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_i           (done_o),
    .ticket_i         (ticket_o),
    .grant_valid_i    (grant_valid_o),
    .grant_id_i       (grant_id_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatch_count),
    .awaiting_o       (awaiting)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("bakery_ticket_arbiter test failed");
    $finish;
  end

  task automatic send_item(input func_e func, input logic [IdBits-1:0] id);
    start_i        <= 1'b1;
    func_i         <= func;
    requester_id_i <= id;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [ActiveBits-1:0] count);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input logic [ActiveBits-1:0] count, input int transfers);
    int                sent;
    int                burst;
    int                span;
    logic [IdBits-1:0] id;
    func_e             func;
    write_active(count);
    span  = (count > 8) ? 8 : count;
    sent  = 0;
    burst = 0;
    while (sent < transfers) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
      end
      if ($urandom_range(0, 9) < 8) id = IdBits'($urandom_range(0, span - 1));
      else id = IdBits'($urandom_range(0, 7));
      func = ($urandom_range(0, 99) < 55) ? FUNC_REQUEST : FUNC_RELEASE;
      send_item(func, id);
      burst--;
      if (id < count) sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // release with nothing held, then a requester asking again while it holds a ticket
    send_item(FUNC_RELEASE, 3'd0);
    send_item(FUNC_REQUEST, 3'd0);
    send_item(FUNC_REQUEST, 3'd7);
    send_item(FUNC_REQUEST, 3'd0);
    send_item(FUNC_RELEASE, 3'd7);
    send_item(FUNC_REQUEST, 3'd5);
    send_item(FUNC_RELEASE, 3'd0);
    send_item(FUNC_RELEASE, 3'd5);
    write_active(4'd0);
    send_item(FUNC_REQUEST, 3'd0);
    send_item(FUNC_RELEASE, 3'd0);
    write_active(4'd1);
    send_item(FUNC_REQUEST, 3'd0);
    send_item(FUNC_REQUEST, 3'd1);
    send_item(FUNC_RELEASE, 3'd7);
    write_active(4'd15);
    send_item(FUNC_REQUEST, 3'd7);
    send_item(FUNC_REQUEST, 3'd6);
    // lowered count leaves stranded holders in the maximum and the grant
    write_active(4'd4);
    send_item(FUNC_REQUEST, 3'd2);
    send_item(FUNC_RELEASE, 3'd7);
    send_item(FUNC_RELEASE, 3'd0);
    write_active(4'd8);
    send_item(FUNC_RELEASE, 3'd7);
    send_item(FUNC_RELEASE, 3'd6);
    send_item(FUNC_RELEASE, 3'd2);

    random_phase(4'd8, 100);
    random_phase(4'd3, 70);
    random_phase(4'd1, 35);
    random_phase(4'd15, 80);
    random_phase(ActiveBits'($urandom_range(2, 7)), 80);
    random_phase(4'd8, 100);

    // clear every holder, then a short random run from empty
    write_active(4'd8);
    for (int i = 0; i < 8; i++) send_item(FUNC_RELEASE, IdBits'(i));
    send_item(FUNC_REQUEST, 3'd3);
    send_item(FUNC_REQUEST, 3'd0);
    send_item(FUNC_RELEASE, 3'd3);
    for (int i = 0; i < 8; i++) send_item(FUNC_RELEASE, IdBits'(7 - i));
    random_phase(4'd8, 30);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("bakery_ticket_arbiter test passed");
    else $display("bakery_ticket_arbiter test failed");
    $finish;
  end

endmodule

### bakery_ticket_arbiter.f
design/bta_pkg.sv
design/bta_cell.sv
design/bakery_ticket_arbiter.sv
test/bakery_ticket_arbiter_checker.sv
test/bakery_ticket_arbiter_test.sv
